// ===== design/linear_move_step_planner_defines.svh =====
// assertion macros for the linear move step planner
`ifndef LINEAR_MOVE_STEP_PLANNER_DEFINES_SVH
`define LINEAR_MOVE_STEP_PLANNER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LMSP_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("planner check failed");

// next-cycle implication, disabled while in reset
`define LMSP_ASSERT_NXT(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("planner check failed");

`endif

// ===== design/lmsp_pkg.sv =====
// shared types, widths and constants of the linear move step planner
`default_nettype none
package lmsp_pkg;

    localparam int NUM_AXES   = 3;
    localparam int AXIS_W     = 2;
    localparam logic [AXIS_W-1:0] AXIS_LAST = 2'd2;

    localparam int MAG_W      = 33;
    localparam int MUL_A_W    = 33;
    localparam int MUL_B_W    = 49;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int SQ_W       = 66;
    localparam int ROOT_W     = 49;
    localparam int DIV_N_W    = 65;
    localparam int DIV_D_W    = 66;
    localparam int NUM_SHIFT  = 16;
    localparam int OUT_W      = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_FEED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEED     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MSTEPS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_Z   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ABS_MODE = 3'd6;

    localparam logic [CFG_DATA_W-1:0] MAX_FEED_RST = 16'd1800;
    localparam logic [CFG_DATA_W-1:0] MSTEPS_RST   = 16'd200;
    localparam logic [CFG_DATA_W-1:0] LEAD_RST     = 16'd8000;

    // 60 s per minute times 1e6 us per s over 1000 um per mm
    localparam logic [31:0] DELAY_SCALE = 32'd60000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_SQ,
        OP_SQRT,
        OP_STEP_MUL,
        OP_STEP_DIV,
        OP_NUM_MUL,
        OP_DEN_MUL,
        OP_DLY_DIV
    } op_t;

    function automatic logic [OUT_W-1:0] sat32(input logic [DIV_N_W-1:0] q);
        logic [OUT_W-1:0] r;
        r = (|q[DIV_N_W-1:OUT_W]) ? '1 : q[OUT_W-1:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/lmsp_mul.sv =====
// shift-add multiplier, one multiplier bit per cycle
`default_nettype none
module lmsp_mul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lmsp_pkg::MUL_A_W-1:0] a,
    input  logic [lmsp_pkg::MUL_B_W-1:0] b,
    output logic                         done,
    output logic [lmsp_pkg::PROD_W-1:0]  prod
);
    import lmsp_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W);

    logic [MUL_A_W-1:0] a_reg;
    logic [MUL_A_W:0]   hi_reg;
    logic [MUL_B_W-1:0] lo_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [MUL_A_W:0]   sum;

    assign sum = hi_reg + (lo_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MUL_B_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= {1'b0, sum[MUL_A_W:1]};
            lo_reg <= {sum[0], lo_reg[MUL_B_W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg[MUL_A_W-1:0], lo_reg};

endmodule
`default_nettype wire

// ===== design/lmsp_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module lmsp_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lmsp_pkg::DIV_N_W-1:0] num,
    input  logic [lmsp_pkg::DIV_D_W-1:0] den,
    output logic                         done,
    output logic [lmsp_pkg::DIV_N_W-1:0] quot
);
    import lmsp_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W);

    logic [DIV_D_W-1:0] r_reg;
    logic [DIV_N_W-1:0] q_reg;
    logic [DIV_D_W-1:0] d_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DIV_D_W:0]   rem_shift;
    logic [DIV_D_W:0]   diff;
    logic               ge;

    assign rem_shift = {r_reg, q_reg[DIV_N_W-1]};
    assign diff      = rem_shift - {1'b0, d_reg};
    assign ge        = (rem_shift >= {1'b0, d_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_N_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= '0;
            q_reg <= num;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            r_reg <= ge ? diff[DIV_D_W-1:0] : rem_shift[DIV_D_W-1:0];
            q_reg <= {q_reg[DIV_N_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule
`default_nettype wire

// ===== design/lmsp_sqrt.sv =====
// restoring integer square root, one root bit per cycle
`default_nettype none
module lmsp_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lmsp_pkg::SQ_W-1:0]   s,
    output logic                        done,
    output logic [lmsp_pkg::ROOT_W-1:0] root
);
    import lmsp_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);
    localparam int N_W   = 2 * ROOT_W;

    logic [N_W-1:0]    n_reg;
    logic [ROOT_W:0]   r_reg;
    logic [ROOT_W-1:0] q_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [ROOT_W+2:0] r_shift;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] diff;
    logic              ge;

    assign r_shift = {r_reg, n_reg[N_W-1 -: 2]};
    assign trial   = {1'b0, q_reg, 2'b01};
    assign diff    = r_shift - trial;
    assign ge      = (r_shift >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // radicand is s scaled by 2^32
            n_reg <= {s, {(N_W - SQ_W){1'b0}}};
            r_reg <= '0;
            q_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[N_W-3:0], 2'b00};
            r_reg <= ge ? diff[ROOT_W:0] : r_shift[ROOT_W:0];
            q_reg <= {q_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = q_reg;

endmodule
`default_nettype wire

// ===== design/linear_move_step_planner.sv =====
// linear move step planner top level: sequencer, per-axis registers, output register
// an item is finished and its result loaded into the output register before the next is
// accepted; twelve multiplies, six divides and one square root run in turn on three
// shared bit-serial units
// the next item is accepted while a finished result waits in the output register
// rst_n clears positions, control state and loads the configuration reset values
`default_nettype none
`include "linear_move_step_planner_defines.svh"
module linear_move_step_planner #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lmsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lmsp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [COORD_WIDTH-1:0]   target_x,
    input  logic signed [COORD_WIDTH-1:0]   target_y,
    input  logic signed [COORD_WIDTH-1:0]   target_z,
    input  logic                            rapid,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [lmsp_pkg::OUT_W-1:0]      steps_x,
    output logic                            dir_x,
    output logic [lmsp_pkg::OUT_W-1:0]      delay_x,
    output logic [lmsp_pkg::OUT_W-1:0]      steps_y,
    output logic                            dir_y,
    output logic [lmsp_pkg::OUT_W-1:0]      delay_y,
    output logic [lmsp_pkg::OUT_W-1:0]      steps_z,
    output logic                            dir_z,
    output logic [lmsp_pkg::OUT_W-1:0]      delay_z,
    output logic                            feed_clamped
);
    import lmsp_pkg::*;

    // configuration
    logic [CFG_DATA_W-1:0] max_feed_reg;
    logic [CFG_DATA_W-1:0] feed_reg;
    logic [CFG_DATA_W-1:0] msr_reg;
    logic [CFG_DATA_W-1:0] lead_reg [NUM_AXES];
    logic                  abs_reg;

    // sequencer
    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [AXIS_W-1:0] axis_reg, axis_next;
    logic              launched_reg;

    // per-move data
    logic signed [31:0]     pos_reg [NUM_AXES];
    logic [MAG_W-1:0]       mag_reg [NUM_AXES];
    logic                   dir_reg [NUM_AXES];
    logic                   clamped_reg;
    logic [MUL_A_W-1:0]     msf_reg;
    logic [SQ_W-1:0]        s_reg;
    logic [ROOT_W-1:0]      dq_reg;
    logic [SQ_W-1:0]        tmp_reg;
    logic [DIV_N_W-1:0]     num_reg;
    logic [OUT_W-1:0]       steps_reg [NUM_AXES];
    logic [OUT_W-1:0]       delay_reg [NUM_AXES];

    // output register
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_steps_reg [NUM_AXES];
    logic [OUT_W-1:0]       out_delay_reg [NUM_AXES];
    logic                   out_dir_reg [NUM_AXES];
    logic                   out_clamped_reg;

    logic                   in_acc;
    logic                   out_load;
    logic                   mul_start, div_start, sqrt_start;
    logic                   mul_done, div_done, sqrt_done, unit_done;
    logic [MUL_A_W-1:0]     mul_a;
    logic [MUL_B_W-1:0]     mul_b;
    logic [PROD_W-1:0]      mul_prod;
    logic [DIV_N_W-1:0]     div_n;
    logic [DIV_D_W-1:0]     div_d;
    logic [DIV_N_W-1:0]     div_quot;
    logic [ROOT_W-1:0]      root;

    logic signed [COORD_WIDTH-1:0] tgt [NUM_AXES];
    logic signed [32:0]     delta [NUM_AXES];
    logic [MAG_W-1:0]       mag_new [NUM_AXES];
    logic signed [31:0]     pos_new [NUM_AXES];
    logic [CFG_DATA_W-1:0]  feed_sel;
    logic                   clamp_new;
    logic [MAG_W-1:0]       mag_sel;
    logic [CFG_DATA_W-1:0]  lead_sel;
    logic [31:0]            lead_scaled;

    assign tgt[0] = target_x;
    assign tgt[1] = target_y;
    assign tgt[2] = target_z;

    assign in_acc    = in_valid && !in_stall;
    assign unit_done = mul_done || div_done || sqrt_done;
    assign mag_sel   = mag_reg[axis_reg];
    assign lead_sel  = lead_reg[axis_reg];
    assign lead_scaled = 32'(lead_sel) * DELAY_SCALE;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            delta[i] = abs_reg ? (33'(tgt[i]) - 33'(pos_reg[i])) : 33'(tgt[i]);
            mag_new[i] = delta[i][32] ? MAG_W'(-delta[i]) : MAG_W'(delta[i]);
            // position plus delta is the target itself in absolute mode
            pos_new[i] = abs_reg ? 32'(tgt[i]) : (pos_reg[i] + 32'(tgt[i]));
        end
    end

    always_comb
    begin
        clamp_new = 1'b0;
        if (rapid)
        begin
            feed_sel = max_feed_reg;
        end
        else if (feed_reg > max_feed_reg)
        begin
            feed_sel  = max_feed_reg;
            clamp_new = 1'b1;
        end
        else
        begin
            feed_sel = feed_reg;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_feed_reg <= MAX_FEED_RST;
            feed_reg     <= '0;
            msr_reg      <= MSTEPS_RST;
            lead_reg[0]  <= LEAD_RST;
            lead_reg[1]  <= LEAD_RST;
            lead_reg[2]  <= LEAD_RST;
            abs_reg      <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_FEED: max_feed_reg <= cfg_data;
                REG_FEED:     feed_reg     <= cfg_data;
                REG_MSTEPS:   msr_reg      <= cfg_data;
                REG_LEAD_X:   lead_reg[0]  <= cfg_data;
                REG_LEAD_Y:   lead_reg[1]  <= cfg_data;
                REG_LEAD_Z:   lead_reg[2]  <= cfg_data;
                REG_ABS_MODE: abs_reg      <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                    state_next = S_RUN;
            end
            S_RUN:
            begin
                if (unit_done && op_reg == OP_DLY_DIV && axis_reg == AXIS_LAST)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall   = 1'b1;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE: in_stall = 1'b0;
            S_RUN:
            begin
                if (!launched_reg)
                begin
                    case (op_reg)
                        OP_SQRT:                  sqrt_start = 1'b1;
                        OP_STEP_DIV, OP_DLY_DIV:  div_start  = 1'b1;
                        default:                  mul_start  = 1'b1;
                    endcase
                end
            end
            S_DONE: out_load = !out_valid_reg || !out_stall;
            default: ;
        endcase
    end

    // op sequence: squares per axis, root, then five ops per axis
    always_comb
    begin
        op_next   = op_reg;
        axis_next = axis_reg;
        case (op_reg)
            OP_SQ:
            begin
                if (axis_reg == AXIS_LAST)
                begin
                    op_next   = OP_SQRT;
                    axis_next = '0;
                end
                else
                begin
                    axis_next = axis_reg + 1'b1;
                end
            end
            OP_SQRT:     op_next = OP_STEP_MUL;
            OP_STEP_MUL: op_next = OP_STEP_DIV;
            OP_STEP_DIV: op_next = OP_NUM_MUL;
            OP_NUM_MUL:  op_next = OP_DEN_MUL;
            OP_DEN_MUL:  op_next = OP_DLY_DIV;
            OP_DLY_DIV:
            begin
                op_next = OP_STEP_MUL;
                if (axis_reg != AXIS_LAST)
                    axis_next = axis_reg + 1'b1;
            end
            default: op_next = OP_SQ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= OP_SQ;
            axis_reg     <= '0;
            launched_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg[0]   <= '0;
            pos_reg[1]   <= '0;
            pos_reg[2]   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                op_reg   <= OP_SQ;
                axis_reg <= '0;
                for (int i = 0; i < NUM_AXES; i++)
                    pos_reg[i] <= pos_new[i];
            end
            else if (unit_done)
            begin
                op_reg   <= op_next;
                axis_reg <= axis_next;
            end
            if (mul_start || div_start || sqrt_start)
                launched_reg <= 1'b1;
            else if (unit_done)
                launched_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // unit operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        div_n = '0;
        div_d = '0;
        case (op_reg)
            OP_SQ:
            begin
                mul_a = mag_sel;
                mul_b = MUL_B_W'(mag_sel);
            end
            OP_STEP_MUL:
            begin
                mul_a = mag_sel;
                mul_b = MUL_B_W'(msr_reg);
            end
            OP_NUM_MUL:
            begin
                mul_a = MUL_A_W'(lead_scaled);
                mul_b = MUL_B_W'(dq_reg);
            end
            OP_DEN_MUL:
            begin
                mul_a = msf_reg;
                mul_b = MUL_B_W'(mag_sel);
            end
            OP_STEP_DIV:
            begin
                div_n = DIV_N_W'(tmp_reg);
                div_d = DIV_D_W'(lead_sel);
            end
            OP_DLY_DIV:
            begin
                div_n = num_reg;
                div_d = DIV_D_W'(tmp_reg);
            end
            default: ;
        endcase
    end

    // per-move datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                mag_reg[i] <= mag_new[i];
                dir_reg[i] <= delta[i][32];
            end
            clamped_reg <= clamp_new;
            msf_reg     <= {32'(msr_reg) * 32'(feed_sel), 1'b0};
            s_reg       <= '0;
        end
        else if (unit_done)
        begin
            case (op_reg)
                OP_SQ:       s_reg   <= s_reg + SQ_W'(mul_prod);
                OP_SQRT:     dq_reg  <= root;
                OP_STEP_MUL: tmp_reg <= SQ_W'(mul_prod);
                OP_STEP_DIV:
                    steps_reg[axis_reg] <= (mag_sel == '0) ? '0 : sat32(div_quot);
                // the 2^16 scale of the root folds into the numerator
                OP_NUM_MUL:  num_reg <= mul_prod[NUM_SHIFT +: DIV_N_W];
                OP_DEN_MUL:  tmp_reg <= SQ_W'(mul_prod);
                OP_DLY_DIV:
                    delay_reg[axis_reg] <= (mag_sel == '0) ? '0 : sat32(div_quot);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                out_steps_reg[i] <= steps_reg[i];
                out_delay_reg[i] <= delay_reg[i];
                out_dir_reg[i]   <= dir_reg[i];
            end
            out_clamped_reg <= clamped_reg;
        end
    end

    lmsp_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    lmsp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_n),
        .den   (div_d),
        .done  (div_done),
        .quot  (div_quot)
    );

    lmsp_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .s     (s_reg),
        .done  (sqrt_done),
        .root  (root)
    );

    assign out_valid    = out_valid_reg;
    assign steps_x      = out_steps_reg[0];
    assign steps_y      = out_steps_reg[1];
    assign steps_z      = out_steps_reg[2];
    assign delay_x      = out_delay_reg[0];
    assign delay_y      = out_delay_reg[1];
    assign delay_z      = out_delay_reg[2];
    assign dir_x        = out_dir_reg[0];
    assign dir_y        = out_dir_reg[1];
    assign dir_z        = out_dir_reg[2];
    assign feed_clamped = out_clamped_reg;

    `LMSP_ASSERT_NXT(a_accept_runs, clk, rst_n, in_acc, state_reg == S_RUN)
    `LMSP_ASSERT_IMP(a_one_unit, clk, rst_n, 1'b1, $onehot0({mul_done, div_done, sqrt_done}))
    `LMSP_ASSERT_IMP(a_done_launched, clk, rst_n, unit_done,
        state_reg == S_RUN && launched_reg)
    `LMSP_ASSERT_IMP(a_load_free, clk, rst_n, out_load, state_reg == S_DONE)

endmodule
`default_nettype wire
